[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Strict priority task queue package
// Shared codes and the control word passed from the queue control to the top.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Number of priority levels, each with its own ring in the task memory.
    localparam int NUM_LEVELS = 3;

    // Command codes carried in s_tuser.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Priority level codes; the unused code is treated as low on a push.
    localparam logic [1:0] LVL_HIGH   = 2'd0;
    localparam logic [1:0] LVL_NORMAL = 2'd1;
    localparam logic [1:0] LVL_LOW    = 2'd2;
    localparam logic [1:0] LVL_UNUSED = 2'd3;

    // Result status codes carried in m_tuser.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Decision for one word, made by the queue control.
    typedef struct packed {
        logic       wr_en;    // push goes into the task memory
        logic       rd_en;    // pop reads the task memory
        logic [1:0] status;   // result status
        logic [1:0] level;    // level of the popped task, high otherwise
        logic       pending;  // some queue holds a task after this word
    } spq_op_t;

endpackage

[hdl/spq_store.sv]
// ----------------------------------------------------------------------------
// Task memory
// Simple dual-port memory holding all three rings, one registered read port.
// ----------------------------------------------------------------------------
module spq_store #(
    parameter int ENTRIES   = 48,
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [ENTRIES];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// Queue control
// Head, tail and fill count per level, priority select and memory addressing.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ADDR_BITS   = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 cmd,
    input  logic [1:0]           level,
    output spq_pkg::spq_op_t     op,
    output logic [ADDR_BITS-1:0] addr
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [ADDR_BITS-1:0] BASE_NORMAL = ADDR_BITS'(QUEUE_DEPTH);
    localparam logic [ADDR_BITS-1:0] BASE_LOW    = ADDR_BITS'(2 * QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0]  PTR_LAST    = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0]  CNT_FULL    = CNT_BITS'(QUEUE_DEPTH);

    logic [PTR_BITS-1:0] head_reg  [spq_pkg::NUM_LEVELS];
    logic [PTR_BITS-1:0] head_next [spq_pkg::NUM_LEVELS];
    logic [PTR_BITS-1:0] tail_reg  [spq_pkg::NUM_LEVELS];
    logic [PTR_BITS-1:0] tail_next [spq_pkg::NUM_LEVELS];
    logic [CNT_BITS-1:0] count_reg [spq_pkg::NUM_LEVELS];
    logic [CNT_BITS-1:0] count_next[spq_pkg::NUM_LEVELS];

    logic [spq_pkg::NUM_LEVELS-1:0] nonempty;
    logic [1:0]          push_lvl;
    logic [1:0]          pop_lvl;
    logic [1:0]          act_lvl;
    logic                is_push;
    logic                found;
    logic                full;
    logic [PTR_BITS-1:0] ptr;
    logic [ADDR_BITS-1:0] base;

    // Level selection: pushes by their own level, pops by strict priority.
    always_comb begin
        for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
            nonempty[l] = (count_reg[l] != '0);
        end
        is_push  = (cmd == spq_pkg::CMD_PUSH);
        push_lvl = (level == spq_pkg::LVL_UNUSED) ? spq_pkg::LVL_LOW : level;
        if (nonempty[0]) begin
            pop_lvl = spq_pkg::LVL_HIGH;
        end else if (nonempty[1]) begin
            pop_lvl = spq_pkg::LVL_NORMAL;
        end else begin
            pop_lvl = spq_pkg::LVL_LOW;
        end
        found   = |nonempty;
        act_lvl = is_push ? push_lvl : pop_lvl;
        full    = (count_reg[act_lvl] == CNT_FULL);
    end

    // Memory address: ring base of the level plus tail or head.
    always_comb begin
        ptr = is_push ? tail_reg[act_lvl] : head_reg[act_lvl];
        case (act_lvl)
            spq_pkg::LVL_HIGH:   base = '0;
            spq_pkg::LVL_NORMAL: base = BASE_NORMAL;
            default:             base = BASE_LOW;
        endcase
        addr = base + ADDR_BITS'(ptr);
    end

    // Pointer and count updates, then the decision word.
    always_comb begin
        op.wr_en = is_push && !full;
        op.rd_en = !is_push && found;
        for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
            head_next[l]  = head_reg[l];
            tail_next[l]  = tail_reg[l];
            count_next[l] = count_reg[l];
            if (op.rd_en && (pop_lvl == 2'(l))) begin
                head_next[l]  = (head_reg[l] == PTR_LAST) ? '0 : head_reg[l] + 1'b1;
                count_next[l] = count_reg[l] - 1'b1;
            end
            if (op.wr_en && (push_lvl == 2'(l))) begin
                tail_next[l]  = (tail_reg[l] == PTR_LAST) ? '0 : tail_reg[l] + 1'b1;
                count_next[l] = count_reg[l] + 1'b1;
            end
        end
        if (is_push) begin
            op.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
        end else begin
            op.status = found ? spq_pkg::ST_DONE : spq_pkg::ST_EMPTY;
        end
        op.level   = op.rd_en ? pop_lvl : spq_pkg::LVL_HIGH;
        op.pending = (count_next[0] != '0) || (count_next[1] != '0) ||
                     (count_next[2] != '0);
    end

    // Ring state, updated on each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else if (accept) begin
            for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
                head_reg[l]  <= head_next[l];
                tail_reg[l]  <= tail_next[l];
                count_reg[l] <= count_next[l];
            end
        end
    end

    // A fill count never passes the ring depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= CNT_FULL) && (count_reg[1] <= CNT_FULL) &&
        (count_reg[2] <= CNT_FULL))
        else $error("fill count above queue depth");

    // A word never writes and reads the memory at once.
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(op.wr_en && op.rd_en))
        else $error("write and read in the same word");

    // An accepted pop that reads from the high level leaves it one entry shorter.
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op.rd_en && (pop_lvl == spq_pkg::LVL_HIGH)) |=>
        (count_reg[0] == $past(count_reg[0]) - 1'b1))
        else $error("pop did not shrink the high queue");

endmodule

[hdl/strict_priority_task_queue_unit.sv]
// ----------------------------------------------------------------------------
// Strict priority task queue
// Three FIFO rings (high, normal, low) of task identifiers in one memory.
//
//   channel  dir  word                                  handshake
//   s_       in   tuser: cmd; tdata: level, task_id     s_tvalid / s_tready
//   m_       out  tuser: status; tdata: id, lvl, pend   m_tvalid / m_tready
//
// One word is taken per cycle while s_tready is high. Its result word is
// presented on m_ from the output register. The two stages are the
// registered memory read and the output register.
// Reset clears the head, tail and count registers; the memory is not cleared
// and needs no clearing pass, since only filled entries are read.
// s_tready drops only when both the read stage and the output register hold
// words and m_tready is low.
// ----------------------------------------------------------------------------
module strict_priority_task_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] level, [9:2] task_id, rest zero
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] popped_id, [9:8] popped_level,
                                   // [10] any_pending, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int ENTRIES    = spq_pkg::NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_BITS  = $clog2(ENTRIES);
    localparam int STORE_BITS = (ID_BITS < 8) ? ID_BITS : 8;

    logic                  accept;
    spq_pkg::spq_op_t      op;
    logic [ADDR_BITS-1:0]  addr;
    logic [STORE_BITS-1:0] rd_data;

    // Read stage: decision of the word whose memory read is in flight.
    logic       s1_vld_reg;
    logic       s1_found_reg;
    logic [1:0] s1_status_reg;
    logic [1:0] s1_level_reg;
    logic       s1_pending_reg;
    logic       s1_advance;

    // Output register.
    logic       m_vld_reg;
    logic [7:0] m_id_reg;
    logic [1:0] m_level_reg;
    logic       m_pending_reg;
    logic [1:0] m_status_reg;
    logic       m_free;

    assign m_free     = !m_vld_reg || m_tready;
    assign s1_advance = s1_vld_reg && m_free;
    assign s_tready   = !s1_vld_reg || m_free;
    assign accept     = s_tvalid && s_tready;

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cmd     (s_tuser),
        .level   (s_tdata[1:0]),
        .op      (op),
        .addr    (addr)
    );

    spq_store #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (STORE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && op.wr_en),
        .wr_addr (addr),
        .wr_data (s_tdata[2 +: STORE_BITS]),
        .rd_en   (accept && op.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Read stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (accept) begin
            s1_vld_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_vld_reg <= 1'b0;
        end
    end

    // Read stage payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_found_reg   <= op.rd_en;
            s1_status_reg  <= op.status;
            s1_level_reg   <= op.level;
            s1_pending_reg <= op.pending;
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (m_free) begin
            m_vld_reg <= s1_vld_reg;
        end
    end

    // Output register payload; the memory data is used only by a found pop.
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_id_reg      <= s1_found_reg ? 8'(rd_data) : 8'd0;
            m_level_reg   <= s1_level_reg;
            m_pending_reg <= s1_pending_reg;
            m_status_reg  <= s1_status_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_pending_reg, m_level_reg, m_id_reg};

    // An empty pop means nothing is pending.
    a_empty_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == spq_pkg::ST_EMPTY)) |-> !m_tdata[10])
        else $error("empty pop reports pending tasks");

    // The input stalls only when both stages are occupied.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_vld_reg && m_vld_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    // A word in the read stage reaches the output register when it is free.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && m_free) |=> m_vld_reg)
        else $error("read stage word lost");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Strict priority task queue testbench
// Drives push and pop words into the three-level task queue. A scoreboard
// keeps its own copy of the three priority rings and checks every result
// word field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    // One expected result word, unpacked into its fields.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] popped_id;
        logic [1:0] popped_level;
        logic       any_pending;
    } task_result_t;

    // Traffic shapes for the random part.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_FLOOD
    } traffic_t;

    // Scoreboard: mirrors the three rings and holds the expected results.
    class task_queue_board;
        logic [7:0]   ring [spq_pkg::NUM_LEVELS][$];
        task_result_t awaited[$];
        int           errors;

        function int outstanding();
            return awaited.size();
        endfunction

        // Work out the result of one accepted word and update the rings.
        function void note_word(logic cmd, logic [1:0] lvl, logic [7:0] id);
            task_result_t r;
            int           tgt;
            r = '0;
            r.status = spq_pkg::ST_DONE;
            if (cmd == spq_pkg::CMD_PUSH) begin
                tgt = (lvl == spq_pkg::LVL_UNUSED) ? int'(spq_pkg::LVL_LOW) : int'(lvl);
                if (ring[tgt].size() >= DEPTH) begin
                    r.status = spq_pkg::ST_FULL;
                end else begin
                    ring[tgt].push_back(id);
                end
            end else begin
                r.status = spq_pkg::ST_EMPTY;
                for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
                    if (r.status == spq_pkg::ST_EMPTY && ring[l].size() != 0) begin
                        r.status       = spq_pkg::ST_DONE;
                        r.popped_id    = ring[l].pop_front();
                        r.popped_level = 2'(l);
                    end
                end
            end
            for (int l = 0; l < spq_pkg::NUM_LEVELS; l++) begin
                if (ring[l].size() != 0) begin
                    r.any_pending = 1'b1;
                end
            end
            awaited.push_back(r);
        endfunction

        // Compare one accepted result word with the oldest expectation.
        function void check_result(logic [15:0] tdata, logic [1:0] tuser);
            task_result_t e;
            if (awaited.size() == 0) begin
                $error("unexpected result word: tdata %h tuser %h", tdata, tuser);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (tuser !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, tuser);
                errors++;
            end
            if (tdata[7:0] !== e.popped_id) begin
                $error("popped_id: expected %0d, actual %0d", e.popped_id, tdata[7:0]);
                errors++;
            end
            if (tdata[9:8] !== e.popped_level) begin
                $error("popped_level: expected %0d, actual %0d",
                       e.popped_level, tdata[9:8]);
                errors++;
            end
            if (tdata[10] !== e.any_pending) begin
                $error("any_pending: expected %0d, actual %0d",
                       e.any_pending, tdata[10]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = spq_pkg::CMD_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    task_queue_board board = new();
    bit              send_idle = 1'b1;
    bit              recv_idle = 1'b1;
    int              stall_left = 0;

    strict_priority_task_queue_unit #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS    (8)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock, 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: check accepted words and stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tuser);
        end
        if (recv_idle && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6);
        end
        if (recv_idle && stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one word, with an optional idle burst first, until accepted.
    task automatic send_word(logic cmd, logic [1:0] lvl, logic [7:0] id);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, id, lvl};
        do @(posedge aclk); while (!s_tready);
        board.note_word(cmd, lvl, id);
    endtask

    // Stop sending until every expected result word has arrived.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    // Edge cases: empty pop, every level, the unused level, a full ring.
    task automatic run_directed();
        send_word(spq_pkg::CMD_POP, spq_pkg::LVL_UNUSED, 8'hFF);
        send_word(spq_pkg::CMD_PUSH, spq_pkg::LVL_HIGH, 8'h00);
        send_word(spq_pkg::CMD_PUSH, spq_pkg::LVL_NORMAL, 8'hFF);
        send_word(spq_pkg::CMD_PUSH, spq_pkg::LVL_UNUSED, 8'h5A);
        send_word(spq_pkg::CMD_PUSH, spq_pkg::LVL_LOW, 8'hA5);
        // Level on a pop is ignored; strict order high, normal, low.
        send_word(spq_pkg::CMD_POP, spq_pkg::LVL_LOW, 8'h00);
        send_word(spq_pkg::CMD_POP, spq_pkg::LVL_UNUSED, 8'h33);
        send_word(spq_pkg::CMD_POP, spq_pkg::LVL_HIGH, 8'hCC);
        send_word(spq_pkg::CMD_POP, spq_pkg::LVL_NORMAL, 8'h00);
        send_word(spq_pkg::CMD_POP, spq_pkg::LVL_HIGH, 8'h00);
        // Fill the normal ring; the last push is refused.
        for (int i = 0; i <= DEPTH; i++) begin
            send_word(spq_pkg::CMD_PUSH, spq_pkg::LVL_NORMAL, 8'(i * 15));
        end
    endtask

    // Random traffic in segments of one shape each.
    task automatic run_random(int count, bit allow_idle);
        traffic_t   shape;
        logic [1:0] flood_lvl;
        logic       cmd;
        logic [1:0] lvl;
        int         seg_len;
        int         sent;
        sent = 0;
        while (sent < count) begin
            shape     = traffic_t'($urandom_range(0, 3));
            flood_lvl = 2'($urandom_range(0, 3));
            seg_len   = $urandom_range(8, 60);
            send_idle = allow_idle && ($urandom_range(0, 3) != 0);
            recv_idle = allow_idle && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < seg_len && sent < count; i++) begin
                lvl = 2'($urandom_range(0, 3));
                case (shape)
                    MIX_FILL: begin
                        cmd = ($urandom_range(0, 9) == 0) ? spq_pkg::CMD_POP
                                                          : spq_pkg::CMD_PUSH;
                    end
                    MIX_DRAIN: begin
                        cmd = ($urandom_range(0, 9) != 0) ? spq_pkg::CMD_POP
                                                          : spq_pkg::CMD_PUSH;
                    end
                    MIX_EVEN: begin
                        cmd = $urandom_range(0, 1) ? spq_pkg::CMD_POP : spq_pkg::CMD_PUSH;
                    end
                    default: begin
                        cmd = ($urandom_range(0, 7) == 0) ? spq_pkg::CMD_POP
                                                          : spq_pkg::CMD_PUSH;
                        lvl = flood_lvl;
                    end
                endcase
                send_word(cmd, lvl, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        hold_until_drained();
        run_random(900, 1'b1);
        hold_until_drained();
        run_random(850, 1'b1);
        // Closing stretch at full rate on both sides.
        run_random(150, 1'b0);
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_store.sv
hdl/spq_ctrl.sv
hdl/strict_priority_task_queue_unit.sv
test/tb.sv
